FILE: rtl/core/button_press_duration_classifier_assert.svh
// Assertion macros used by the button press duration classifier core
`ifndef BUTTON_PRESS_DURATION_CLASSIFIER_ASSERT_SVH
`define BUTTON_PRESS_DURATION_CLASSIFIER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BPDC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bpdc assertion failed");

// next-cycle implication, checked out of reset
`define BPDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bpdc assertion failed");

`endif

FILE: rtl/core/bpdc_pkg.sv
// Types and constants of the button press duration classifier
package bpdc_pkg;

   localparam int CFG_W       = 16;
   localparam int HELD_W      = 16;
   localparam int CSR_INDEX_W = 2;

   localparam logic [HELD_W-1:0] HELD_MAX = {HELD_W{1'b1}};

   localparam logic [CFG_W-1:0] DEBOUNCE_RESET  = 16'd50;
   localparam logic [CFG_W-1:0] PULSE_MIN_RESET = 16'd200;
   localparam logic [CFG_W-1:0] SHORT_MIN_RESET = 16'd1000;
   localparam logic [CFG_W-1:0] LONG_MIN_RESET  = 16'd2000;

   typedef enum logic [1:0] {
      CLASS_NONE  = 2'd0,
      CLASS_PULSE = 2'd1,
      CLASS_SHORT = 2'd2,
      CLASS_LONG  = 2'd3
   } press_class_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEBOUNCE  = 2'd0,
      CSR_PULSE_MIN = 2'd1,
      CSR_SHORT_MIN = 2'd2,
      CSR_LONG_MIN  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [CFG_W-1:0] debounce_ticks;
      logic [CFG_W-1:0] pulse_min_ticks;
      logic [CFG_W-1:0] short_min_ticks;
      logic [CFG_W-1:0] long_min_ticks;
   } cfg_type;

   typedef struct packed {
      press_class_type   press_class;
      logic [HELD_W-1:0] held_ticks;
   } rsp_type;

endpackage

FILE: rtl/core/bpdc_channels.sv
// Valid/ready channel interfaces of the button press duration classifier
interface bpdc_req_if;
   logic valid;
   logic ready;
   logic btn_level;

   modport source (output valid, output btn_level, input ready);
   modport sink (input valid, input btn_level, output ready);
endinterface

interface bpdc_rsp_if;
   logic                             valid;
   logic                             ready;
   bpdc_pkg::press_class_type        press_class;
   logic [bpdc_pkg::HELD_W-1:0]      held_ticks;

   modport source (output valid, output press_class, output held_ticks, input ready);
   modport sink (input valid, input press_class, input held_ticks, output ready);
endinterface

FILE: rtl/core/bpdc_core.sv
// Debounce and hold tracker with press duration classification
`include "button_press_duration_classifier_assert.svh"

module bpdc_core #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic              pressed,
   input  bpdc_pkg::cfg_type cfg,
   output logic              result_valid,
   output bpdc_pkg::rsp_type result_data
);
   import bpdc_pkg::*;

   localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_DEBOUNCE = 2'd1,
      PH_HOLD     = 2'd2
   } phase_type;

   phase_type               phase_ff;
   phase_type               phase_in;
   logic [COUNT_WIDTH-1:0]  tick_count_ff;
   logic [COUNT_WIDTH-1:0]  tick_count_in;
   logic [COUNT_WIDTH-1:0]  count_up;
   logic [CMP_W-1:0]        count_ext;

   always_comb begin
      count_up  = (tick_count_ff == COUNT_MAX) ? tick_count_ff
                                               : tick_count_ff + 1'b1;
      count_ext = CMP_W'(count_up);
   end

   always_comb begin
      if (count_ext >= CMP_W'(cfg.long_min_ticks)) begin
         result_data.press_class = CLASS_LONG;
      end else if (count_ext >= CMP_W'(cfg.short_min_ticks)) begin
         result_data.press_class = CLASS_SHORT;
      end else if (count_ext >= CMP_W'(cfg.pulse_min_ticks)) begin
         result_data.press_class = CLASS_PULSE;
      end else begin
         result_data.press_class = CLASS_NONE;
      end
      if (count_ext > CMP_W'(HELD_MAX)) begin
         result_data.held_ticks = HELD_MAX;
      end else begin
         result_data.held_ticks = count_ext[HELD_W-1:0];
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      tick_count_in = tick_count_ff;
      result_valid  = 1'b0;
      if (step) begin
         case (phase_ff)
            PH_DEBOUNCE: begin
               tick_count_in = count_up;
               if (count_ext >= CMP_W'(cfg.debounce_ticks)) begin
                  tick_count_in = '0;
                  phase_in      = pressed ? PH_HOLD : PH_IDLE;
               end
            end
            PH_HOLD: begin
               tick_count_in = count_up;
               if (!pressed) begin
                  result_valid  = 1'b1;
                  tick_count_in = '0;
                  phase_in      = PH_IDLE;
               end
            end
            default: begin
               tick_count_in = '0;
               phase_in      = pressed ? PH_DEBOUNCE : PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         tick_count_ff <= '0;
      end else begin
         phase_ff      <= phase_in;
         tick_count_ff <= tick_count_in;
      end
   end

   `BPDC_ASSERT_IMPL(a_result_only_from_hold, clock, reset, result_valid, phase_ff == PH_HOLD)
   `BPDC_ASSERT_IMPL(a_idle_count_clear, clock, reset, phase_ff == PH_IDLE, tick_count_ff == '0)
   `BPDC_ASSERT_NEXT(a_press_starts_debounce, clock, reset, step && pressed && phase_ff == PH_IDLE, phase_ff == PH_DEBOUNCE)
   `BPDC_ASSERT_NEXT(a_hold_count_no_drop, clock, reset, step && pressed && phase_ff == PH_HOLD, tick_count_ff >= $past(tick_count_ff))

endmodule

FILE: rtl/core/button_press_duration_classifier.sv
// Top level of the button press duration classifier
//
// One request transaction is one timer tick carrying the sampled button
// level. A press seen while idle starts a debounce wait of debounce_ticks
// ticks; the level on the last tick of that wait confirms the press or
// drops it. A confirmed press is counted tick by tick, saturating, and
// the tick that shows the button released produces one response
// transaction with the press class (long, short, pulse, else too short)
// and the held duration. Other ticks produce no response.
// A tick is taken every cycle while the response register is empty or
// being drained; the response is registered and shows in the cycle
// after its tick is taken. The response register is the only buffer:
// while the receiver stalls with a response waiting, req_chan.ready
// drops and the tick is held off. The csr_ port writes one threshold
// register per cycle; write only while no tick is in flight. Synchronous
// reset returns to idle, clears the counter and the response valid flag,
// and loads the threshold defaults 50, 200, 1000 and 2000.
module button_press_duration_classifier #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   bpdc_req_if.sink                            req_chan,
   bpdc_rsp_if.source                          rsp_chan,
   input  logic                                csr_wr_en,
   input  logic [bpdc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bpdc_pkg::CFG_W-1:0]          csr_wdata
);
   import bpdc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;
   logic    req_accept;
   logic    result_valid;
   rsp_type result_data;

   assign req_chan.ready   = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept       = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.press_class = rsp_data_ff.press_class;
   assign rsp_chan.held_ticks  = rsp_data_ff.held_ticks;

   bpdc_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (req_accept),
      .pressed      (req_chan.btn_level),
      .cfg          (cfg_ff),
      .result_valid (result_valid),
      .result_data  (result_data)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_DEBOUNCE:  cfg_in.debounce_ticks  = csr_wdata;
            CSR_PULSE_MIN: cfg_in.pulse_min_ticks = csr_wdata;
            CSR_SHORT_MIN: cfg_in.short_min_ticks = csr_wdata;
            CSR_LONG_MIN:  cfg_in.long_min_ticks  = csr_wdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (result_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks  <= DEBOUNCE_RESET;
         cfg_ff.pulse_min_ticks <= PULSE_MIN_RESET;
         cfg_ff.short_min_ticks <= SHORT_MIN_RESET;
         cfg_ff.long_min_ticks  <= LONG_MIN_RESET;
         rsp_valid_ff           <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: dv/testbench.sv
// Self-checking testbench of the button press duration classifier
module testbench;
   import bpdc_pkg::*;

   localparam int COUNT_W      = 16;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int SQUEEZE_AT   = 12;
   localparam int SQUEEZE_LEN  = 500;
   localparam int RANDOM_TICKS = 1100;

   typedef enum logic [1:0] {
      HS_IDLE     = 2'd0,
      HS_DEBOUNCE = 2'd1,
      HS_HOLD     = 2'd2
   } hold_phase_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CFG_W-1:0] csr_wdata;

   bpdc_req_if req_bus ();
   bpdc_rsp_if rsp_bus ();

   button_press_duration_classifier #(
      .COUNT_WIDTH(COUNT_W)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   bit tick_queue[$];
   rsp_type press_results_due[$];

   logic [CFG_W-1:0] cfg_debounce;
   logic [CFG_W-1:0] cfg_pulse_min;
   logic [CFG_W-1:0] cfg_short_min;
   logic [CFG_W-1:0] cfg_long_min;
   hold_phase_type tracker_state;
   logic [COUNT_W-1:0] tracker_count;

   bit gaps_on;
   int send_gap;
   int recv_gap;
   int squeeze_left;
   int ticks_sent;
   int results_seen;
   int settings_count;
   int errors;
   int cycles;

   function automatic int draw_gap();
      if (!gaps_on || $urandom_range(0, 3) == 0) begin
         return 0;
      end
      return $urandom_range(0, 13);
   endfunction

   function automatic press_class_type classify_duration(input logic [COUNT_W-1:0] dur);
      if (dur >= cfg_long_min) begin
         return CLASS_LONG;
      end else if (dur >= cfg_short_min) begin
         return CLASS_SHORT;
      end else if (dur >= cfg_pulse_min) begin
         return CLASS_PULSE;
      end
      return CLASS_NONE;
   endfunction

   task automatic advance_classifier(input logic level);
      rsp_type due;
      case (tracker_state)
         HS_DEBOUNCE: begin
            if (tracker_count != '1) begin
               tracker_count++;
            end
            if (tracker_count >= cfg_debounce) begin
               tracker_count = '0;
               tracker_state = level ? HS_HOLD : HS_IDLE;
            end
         end
         HS_HOLD: begin
            if (tracker_count != '1) begin
               tracker_count++;
            end
            if (!level) begin
               due.press_class = classify_duration(tracker_count);
               due.held_ticks = (tracker_count > HELD_MAX) ? HELD_MAX : tracker_count[HELD_W-1:0];
               press_results_due.push_back(due);
               tracker_state = HS_IDLE;
               tracker_count = '0;
            end
         end
         default: begin
            tracker_count = '0;
            tracker_state = level ? HS_DEBOUNCE : HS_IDLE;
         end
      endcase
   endtask

   // driver: one tick transaction per handshake
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            advance_classifier(req_bus.btn_level);
            ticks_sent++;
            send_gap = draw_gap();
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (tick_queue.size() > 0) begin
               req_bus.btn_level <= tick_queue.pop_front();
               req_bus.valid <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each result transaction with the oldest prediction
   always @(posedge clock) begin
      rsp_type due;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_gap = 0;
         squeeze_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (press_results_due.size() == 0) begin
               $error("unexpected result: press_class %0d held_ticks %0d",
                      rsp_bus.press_class, rsp_bus.held_ticks);
               errors++;
            end else begin
               due = press_results_due.pop_front();
               if (rsp_bus.press_class !== due.press_class) begin
                  $error("press_class: expected %0d, actual %0d",
                         due.press_class, rsp_bus.press_class);
                  errors++;
               end
               if (rsp_bus.held_ticks !== due.held_ticks) begin
                  $error("held_ticks: expected %0d, actual %0d",
                         due.held_ticks, rsp_bus.held_ticks);
                  errors++;
               end
            end
            results_seen++;
            recv_gap = draw_gap();
            if (results_seen == SQUEEZE_AT) begin
               squeeze_left = SQUEEZE_LEN;
            end
         end
         if (squeeze_left > 0) begin
            squeeze_left--;
            rsp_bus.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic write_csr(input csr_index_type idx, input logic [CFG_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_DEBOUNCE:  cfg_debounce = val;
         CSR_PULSE_MIN: cfg_pulse_min = val;
         CSR_SHORT_MIN: cfg_short_min = val;
         CSR_LONG_MIN:  cfg_long_min = val;
         default: ;
      endcase
   endtask

   task automatic program_thresholds(input logic [CFG_W-1:0] dbn, input logic [CFG_W-1:0] pls,
                                     input logic [CFG_W-1:0] sht, input logic [CFG_W-1:0] lng);
      write_csr(CSR_DEBOUNCE, dbn);
      write_csr(CSR_PULSE_MIN, pls);
      write_csr(CSR_SHORT_MIN, sht);
      write_csr(CSR_LONG_MIN, lng);
      settings_count++;
      @(negedge clock);
   endtask

   task automatic wait_quiet();
      while (tick_queue.size() > 0 || req_bus.valid || press_results_due.size() > 0) begin
         @(negedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   // one press from idle: the debounce level is random until its last tick
   task automatic add_press(input int dbn, input int held, input bit confirm);
      int eff;
      eff = (dbn == 0) ? 1 : dbn;
      tick_queue.push_back(1'b1);
      for (int i = 1; i <= eff; i++) begin
         tick_queue.push_back((i == eff) ? confirm : 1'($urandom_range(0, 1)));
      end
      if (confirm) begin
         repeat (held) tick_queue.push_back(1'b1);
         tick_queue.push_back(1'b0);
      end
   endtask

   initial begin
      int start_count;
      int dbn;
      int pick;
      int mode;
      int eff;
      logic [CFG_W-1:0] th_a;
      logic [CFG_W-1:0] th_b;
      logic [CFG_W-1:0] th_c;
      logic [CFG_W-1:0] swap;

      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.btn_level = 1'b0;
      rsp_bus.ready = 1'b0;
      cfg_debounce = DEBOUNCE_RESET;
      cfg_pulse_min = PULSE_MIN_RESET;
      cfg_short_min = SHORT_MIN_RESET;
      cfg_long_min = LONG_MIN_RESET;
      tracker_state = HS_IDLE;
      tracker_count = '0;
      gaps_on = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // thresholds out of reset
      add_press(int'(DEBOUNCE_RESET), 250, 1'b1);
      add_press(int'(DEBOUNCE_RESET), 0, 1'b0);
      add_press(int'(DEBOUNCE_RESET), 20, 1'b1);
      wait_quiet();

      // each class once, then a press that is not confirmed
      program_thresholds(16'd1, 16'd2, 16'd4, 16'd6);
      add_press(1, 0, 1'b1);
      add_press(1, 1, 1'b1);
      add_press(1, 3, 1'b1);
      add_press(1, 5, 1'b1);
      add_press(1, 0, 1'b0);
      wait_quiet();

      start_count = ticks_sent;
      while (ticks_sent - start_count < RANDOM_TICKS) begin
         pick = $urandom_range(0, 5);
         dbn = (pick == 0) ? 0 : (pick == 1) ? 1 : $urandom_range(2, 12);
         mode = $urandom_range(0, 3);
         th_a = CFG_W'($urandom_range(0, 30));
         th_b = CFG_W'($urandom_range(0, 30));
         th_c = CFG_W'($urandom_range(0, 30));
         case (mode)
            0: begin
               if (th_a > th_b) begin
                  swap = th_a; th_a = th_b; th_b = swap;
               end
               if (th_b > th_c) begin
                  swap = th_b; th_b = th_c; th_c = swap;
               end
               if (th_a > th_b) begin
                  swap = th_a; th_a = th_b; th_b = swap;
               end
            end
            2: begin
               th_a = $urandom_range(0, 1) ? '1 : '0;
               th_b = $urandom_range(0, 1) ? '1 : '0;
               th_c = $urandom_range(0, 1) ? '1 : '0;
            end
            3: begin
               th_a = '0;
               th_c = '1;
            end
            default: ;
         endcase
         gaps_on = ($urandom_range(0, 3) != 0);
         program_thresholds(CFG_W'(dbn), th_a, th_b, th_c);
         eff = (dbn == 0) ? 1 : dbn;
         for (int n = 0; n < 150; ) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
               add_press(dbn, $urandom_range(0, 36), 1'b1);
            end else if (pick < 87) begin
               add_press(dbn, 0, 1'b0);
            end else begin
               repeat ($urandom_range(1, 12)) tick_queue.push_back(1'($urandom_range(0, 1)));
               repeat (eff + 2) tick_queue.push_back(1'b0);
            end
            repeat ($urandom_range(0, 3)) tick_queue.push_back(1'b0);
            n = tick_queue.size();
         end
         repeat (eff + 2) tick_queue.push_back(1'b0);
         wait_quiet();
      end

      repeat (20) @(posedge clock);
      if (press_results_due.size() != 0) begin
         $error("%0d predicted results never arrived", press_results_due.size());
         errors++;
      end
      $display("Sent %0d ticks over %0d threshold settings; checked %0d press results.",
               ticks_sent, settings_count, results_seen);
      $display("Exercised all classes, bouncing debounce, unconfirmed presses, odd thresholds.");
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: button_press_duration_classifier.f
+incdir+rtl/core
rtl/core/bpdc_pkg.sv
rtl/core/bpdc_channels.sv
rtl/core/bpdc_core.sv
rtl/core/button_press_duration_classifier.sv
dv/testbench.sv
